// File: design/gdpi_pkg.sv
// shared constants, types and the arctangent table of the goal direction path integrator
`default_nettype none
package gdpi_pkg;

  localparam int CordicStepsDef = 16;
  localparam int CordW = 34;   // cordic datapath width
  localparam int MulAW = 36;   // multiplicand width
  localparam int MulBW = 18;   // serial multiplier width
  localparam int MulPW = MulAW + MulBW;
  localparam int CntBW = 5;

  localparam logic [1:0] MODE_GOAL = 2'd0;
  localparam logic [1:0] MODE_YAW  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [1:0] REG_MIN_LEVEL = 2'd0;
  localparam logic [1:0] REG_CORR_RATE = 2'd1;
  localparam logic [1:0] REG_FADE      = 2'd2;

  localparam logic [14:0] MIN_LEVEL_RST = 15'd410;
  localparam logic [15:0] CORR_RATE_RST = 16'd19661;
  localparam logic [15:0] FADE_RST      = 16'd65208;

  localparam logic signed [CordW-1:0] INV_GAIN = 34'sd652032875;
  localparam logic [16:0] TRUST_ONE = 17'd32768;

  typedef enum logic [4:0] {
    S_IDLE, S_MAG_R, S_MAG_F, S_MAG_T, S_VEC, S_ROT_W, S_EMA_X, S_EMA_Y, S_FADE,
    S_ROT_Y, S_BR_C, S_BR_S, S_BF_C, S_BF_S, S_SC_R, S_SC_F, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cor_ctl_t;

  function automatic logic [31:0] arc_at(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: design/gdpi_if.sv
// valid/ready channel interfaces for input items and results
`default_nettype none
interface gdpi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] goal_right;
  logic signed [15:0] goal_forward;
  logic [15:0]        yaw_angle;
  logic [31:0]        tick_stamp;
  modport source (output valid, mode, goal_right, goal_forward, yaw_angle, tick_stamp,
                  input ready);
  modport sink (input valid, mode, goal_right, goal_forward, yaw_angle, tick_stamp,
                output ready);
endinterface

interface gdpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] belief_right;
  logic signed [15:0] belief_forward;
  logic               perceiving;
  logic [31:0]        tick_echo;
  modport source (output valid, belief_right, belief_forward, perceiving, tick_echo,
                  input ready);
  modport sink (input valid, belief_right, belief_forward, perceiving, tick_echo,
                output ready);
endinterface
`default_nettype wire

// File: design/gdpi_smul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
`default_nettype none
module gdpi_smul import gdpi_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start_i,
  input  wire logic signed [MulAW-1:0] a_i,
  input  wire logic signed [MulBW-1:0] b_i,
  output logic signed [MulPW-1:0]      p_o,
  output logic                         done_o
);
  logic signed [MulPW-1:0] acc_r, a_r, term;
  logic [MulBW-1:0]        b_r;
  logic [CntBW-1:0]        cnt_r;
  logic                    busy_r, done_r, last;

  assign last = (cnt_r == CntBW'(MulBW - 1));
  assign term = b_r[0] ? a_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      acc_r <= '0;
      a_r   <= MulPW'(a_i);
      b_r   <= b_i;
    end else if (busy_r) begin
      // top bit of the multiplier carries negative weight
      acc_r <= last ? acc_r - term : acc_r + term;
      a_r   <= a_r <<< 1;
      b_r   <= b_r >> 1;
    end
  end

  assign p_o    = acc_r;
  assign done_o = done_r;
endmodule
`default_nettype wire

// File: design/gdpi_cordic.sv
// iterative cordic, rotation or vectoring, one micro-rotation per cycle
`default_nettype none
module gdpi_cordic import gdpi_pkg::*; #(
  parameter int Steps = CordicStepsDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cor_ctl_t                ctl_i,
  input  wire logic signed [CordW-1:0] x_i,
  input  wire logic signed [CordW-1:0] y_i,
  input  wire logic signed [CordW-1:0] z_i,
  output logic signed [CordW-1:0]      x_o,
  output logic signed [CordW-1:0]      y_o,
  output logic signed [CordW-1:0]      z_o,
  output logic                         done_o
);
  localparam int CntW = $clog2(Steps + 1);

  logic signed [CordW-1:0] x_r, y_r, z_r, dx, dy, at;
  logic [CntW-1:0]         cnt_r;
  logic                    busy_r, done_r, vec_r, up, last;

  assign dx   = y_r >>> cnt_r;
  assign dy   = x_r >>> cnt_r;
  assign at   = CordW'({2'b00, arc_at(5'(cnt_r))});
  assign up   = vec_r ? (y_r <= 0) : (z_r >= 0);
  assign last = (cnt_r == CntW'(Steps - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.start) begin
      x_r   <= x_i;
      y_r   <= y_i;
      z_r   <= z_i;
      vec_r <= ctl_i.vectoring;
    end else if (busy_r) begin
      if (up) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign done_o = done_r;
endmodule
`default_nettype wire

// File: design/goal_direction_path_integrator_top.sv
// goal direction path integrator: sequencer, state, config registers and result register
// Use: items arrive on in_ch (valid/ready). A goal item (mode 0) or a yaw item
// (mode 1) is stored and gives no result; mode 3 is dropped. A tick (mode 2)
// produces one transaction on out_ch carrying the trust-scaled egocentric
// belief, the perceiving flag and the echoed tick number.
// A tick is worked by a sequencer that shares one bit-serial 36x18 multiplier
// and one iterative cordic. A tick with a fix takes 11 products and 3 cordic
// passes; without a fix 10 products and one pass. in_ch.ready is high only while
// the sequencer is idle, which it reenters as the result is loaded. A finished
// result waits in the output register; while it waits, goal and yaw items are
// still taken and a new tick runs but holds its result until out_ch has taken
// the previous one.
// Reset (synchronous, rst_n low) clears held vector, yaw, world goal and trust
// to zero and loads the register defaults. Registers are written over the APB
// port at byte addresses 0, 4 and 8 and should be written only when idle.
`default_nettype none
module goal_direction_path_integrator_top import gdpi_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gdpi_in_if.sink          in_ch,
  gdpi_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  state_t state_r, state_nxt;

  logic [14:0] min_level_r;
  logic [15:0] corr_rate_r, fade_r;

  logic signed [15:0] held_right_r, held_forward_r;
  logic [15:0]        held_yaw_r;
  logic               yaw_known_r;
  logic signed [16:0] world_x_r, world_y_r, wx_r, wy_r, cos_r, sin_r;
  logic [16:0]        trust_r;
  logic [31:0]        tick_r, angle_r;
  logic               fix_r, vec_neg_r, op_busy_r;
  logic signed [MulAW-1:0] mag_r, br_r, bf_r;
  logic signed [15:0] res_right_r, res_fwd_r;

  logic               out_valid_r, out_perc_r;
  logic signed [15:0] out_right_r, out_fwd_r;
  logic [31:0]        out_tick_r;

  logic                    is_mul, is_cor, op_start, op_done;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;
  logic                    mul_done, cor_done;
  cor_ctl_t                cor_ctl;
  logic signed [CordW-1:0] cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z, vec_xs, vec_ys;
  logic [31:0]             rot_ang, rot_fold;
  logic                    rot_flip, in_acc, out_free, wr_en;

  function automatic logic signed [16:0] round_q15(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] t;
    t = (v + CordW'(16384)) >>> 15;
    if (t > CordW'(32768)) return 17'sd32768;
    if (t < -CordW'(32768)) return -17'sd32768;
    return t[16:0];
  endfunction

  function automatic logic signed [16:0] ema_upd(input logic signed [16:0] cur,
                                                 input logic signed [MulPW-1:0] p);
    logic signed [MulPW-1:0] q;
    q = ((p + MulPW'(32768)) >>> 16) + MulPW'(cur);
    if (q > MulPW'(32768)) return 17'sd32768;
    if (q < -MulPW'(32768)) return -17'sd32768;
    return q[16:0];
  endfunction

  function automatic logic signed [15:0] scale_out(input logic signed [MulPW-1:0] p);
    logic signed [MulPW-1:0] q;
    q = (p + (MulPW'(1) <<< 29)) >>> 30;
    if (q > MulPW'(32767)) return 16'sd32767;
    if (q < -MulPW'(32768)) return -16'sd32768;
    return q[15:0];
  endfunction

  // configuration port
  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r <= MIN_LEVEL_RST;
      corr_rate_r <= CORR_RATE_RST;
      fade_r      <= FADE_RST;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_MIN_LEVEL: min_level_r <= cfg_pwdata[14:0];
        REG_CORR_RATE: corr_rate_r <= cfg_pwdata[15:0];
        REG_FADE:      fade_r      <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MIN_LEVEL: cfg_prdata = {17'd0, min_level_r};
      REG_CORR_RATE: cfg_prdata = {16'd0, corr_rate_r};
      REG_FADE:      cfg_prdata = {16'd0, fade_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // shared arithmetic units
  assign is_mul = (state_r == S_MAG_R) || (state_r == S_MAG_F) || (state_r == S_MAG_T) ||
                  (state_r == S_EMA_X) || (state_r == S_EMA_Y) || (state_r == S_FADE) ||
                  (state_r == S_BR_C) || (state_r == S_BR_S) || (state_r == S_BF_C) ||
                  (state_r == S_BF_S) || (state_r == S_SC_R) || (state_r == S_SC_F);
  assign is_cor = (state_r == S_VEC) || (state_r == S_ROT_W) || (state_r == S_ROT_Y);
  assign op_start = (is_mul || is_cor) && !op_busy_r;
  assign op_done  = mul_done | cor_done;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MAG_R: begin
        mul_a = MulAW'(held_right_r);
        mul_b = MulBW'(held_right_r);
      end
      S_MAG_F: begin
        mul_a = MulAW'(held_forward_r);
        mul_b = MulBW'(held_forward_r);
      end
      S_MAG_T: begin
        mul_a = MulAW'({1'b0, min_level_r});
        mul_b = MulBW'({1'b0, min_level_r});
      end
      S_EMA_X: begin
        mul_a = MulAW'(wx_r) - MulAW'(world_x_r);
        mul_b = MulBW'({1'b0, corr_rate_r});
      end
      S_EMA_Y: begin
        mul_a = MulAW'(wy_r) - MulAW'(world_y_r);
        mul_b = MulBW'({1'b0, corr_rate_r});
      end
      S_FADE: begin
        mul_a = MulAW'({1'b0, trust_r});
        mul_b = MulBW'({1'b0, fade_r});
      end
      S_BR_C: begin
        mul_a = MulAW'(world_x_r);
        mul_b = MulBW'(cos_r);
      end
      S_BR_S: begin
        mul_a = MulAW'(world_y_r);
        mul_b = MulBW'(sin_r);
      end
      S_BF_C: begin
        mul_a = MulAW'(world_y_r);
        mul_b = MulBW'(cos_r);
      end
      S_BF_S: begin
        mul_a = MulAW'(world_x_r);
        mul_b = MulBW'(sin_r);
      end
      S_SC_R: begin
        mul_a = br_r;
        mul_b = MulBW'({1'b0, trust_r});
      end
      S_SC_F: begin
        mul_a = bf_r;
        mul_b = MulBW'({1'b0, trust_r});
      end
      default: ;
    endcase
  end

  gdpi_smul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(op_start && is_mul),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .p_o    (mul_p),
    .done_o (mul_done)
  );

  // cordic operands: vectoring of the goal vector, or rotation of the inverse gain
  assign vec_xs   = CordW'(held_right_r) <<< 14;
  assign vec_ys   = CordW'(held_forward_r) <<< 14;
  assign rot_ang  = (state_r == S_ROT_W) ? angle_r + {held_yaw_r, 16'd0}
                                         : {held_yaw_r, 16'd0};
  assign rot_flip = rot_ang[31] ^ rot_ang[30];
  assign rot_fold = rot_ang + {rot_flip, 31'd0};

  always_comb begin
    cor_ctl.start     = op_start && is_cor;
    cor_ctl.vectoring = (state_r == S_VEC);
    if (state_r == S_VEC) begin
      cor_x0 = held_right_r[15] ? -vec_xs : vec_xs;
      cor_y0 = held_right_r[15] ? -vec_ys : vec_ys;
      cor_z0 = '0;
    end else begin
      cor_x0 = rot_flip ? -INV_GAIN : INV_GAIN;
      cor_y0 = '0;
      cor_z0 = CordW'(signed'(rot_fold));
    end
  end

  gdpi_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (cor_ctl),
    .x_i   (cor_x0),
    .y_i   (cor_y0),
    .z_i   (cor_z0),
    .x_o   (cor_x),
    .y_o   (cor_y),
    .z_o   (cor_z),
    .done_o(cor_done)
  );

  // sequencer
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_ch.mode == MODE_TICK) state_nxt = S_MAG_R;
      S_MAG_R: if (op_done) state_nxt = S_MAG_F;
      S_MAG_F: if (op_done) state_nxt = S_MAG_T;
      S_MAG_T: begin
        if (op_done) begin
          state_nxt = (yaw_known_r && (MulPW'(mag_r) > mul_p)) ? S_VEC : S_FADE;
        end
      end
      S_VEC:   if (op_done) state_nxt = S_ROT_W;
      S_ROT_W: if (op_done) state_nxt = S_EMA_X;
      S_EMA_X: if (op_done) state_nxt = S_EMA_Y;
      S_EMA_Y: if (op_done) state_nxt = S_ROT_Y;
      S_FADE:  if (op_done) state_nxt = S_ROT_Y;
      S_ROT_Y: if (op_done) state_nxt = S_BR_C;
      S_BR_C:  if (op_done) state_nxt = S_BR_S;
      S_BR_S:  if (op_done) state_nxt = S_BF_C;
      S_BF_C:  if (op_done) state_nxt = S_BF_S;
      S_BF_S:  if (op_done) state_nxt = S_SC_R;
      S_SC_R:  if (op_done) state_nxt = S_SC_F;
      S_SC_F:  if (op_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // architectural state and control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_busy_r      <= 1'b0;
      held_right_r   <= '0;
      held_forward_r <= '0;
      held_yaw_r     <= '0;
      yaw_known_r    <= 1'b0;
      world_x_r      <= '0;
      world_y_r      <= '0;
      trust_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (op_start) op_busy_r <= 1'b1;
      else if (op_done) op_busy_r <= 1'b0;
      if (in_acc && in_ch.mode == MODE_GOAL) begin
        held_right_r   <= in_ch.goal_right;
        held_forward_r <= in_ch.goal_forward;
      end
      if (in_acc && in_ch.mode == MODE_YAW) begin
        held_yaw_r  <= in_ch.yaw_angle;
        yaw_known_r <= 1'b1;
      end
      if (op_done && state_r == S_EMA_X) world_x_r <= ema_upd(world_x_r, mul_p);
      if (op_done && state_r == S_EMA_Y) begin
        world_y_r <= ema_upd(world_y_r, mul_p);
        trust_r   <= TRUST_ONE;
      end
      if (op_done && state_r == S_FADE) trust_r <= mul_p[32:16];
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // working registers of a tick
  always_ff @(posedge clk) begin
    if (in_acc) tick_r <= in_ch.tick_stamp;
    if (op_done) begin
      unique case (state_r)
        S_MAG_R: mag_r <= mul_p[MulAW-1:0];
        S_MAG_F: mag_r <= mag_r + mul_p[MulAW-1:0];
        S_MAG_T: fix_r <= yaw_known_r && (MulPW'(mag_r) > mul_p);
        S_VEC:   angle_r <= {vec_neg_r, 31'd0} + cor_z[31:0];
        S_ROT_W: begin
          wx_r <= round_q15(cor_x);
          wy_r <= round_q15(cor_y);
        end
        S_ROT_Y: begin
          cos_r <= round_q15(cor_x);
          sin_r <= round_q15(cor_y);
        end
        S_BR_C:  br_r <= mul_p[MulAW-1:0];
        S_BR_S:  br_r <= br_r + mul_p[MulAW-1:0];
        S_BF_C:  bf_r <= mul_p[MulAW-1:0];
        S_BF_S:  bf_r <= bf_r - mul_p[MulAW-1:0];
        S_SC_R:  res_right_r <= scale_out(mul_p);
        S_SC_F:  res_fwd_r <= scale_out(mul_p);
        default: ;
      endcase
    end
    if (op_start && state_r == S_VEC) vec_neg_r <= held_right_r[15];
    if (state_r == S_DONE && out_free) begin
      out_right_r <= res_right_r;
      out_fwd_r   <= res_fwd_r;
      out_perc_r  <= fix_r;
      out_tick_r  <= tick_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.belief_right   = out_right_r;
  assign out_ch.belief_forward = out_fwd_r;
  assign out_ch.perceiving     = out_perc_r;
  assign out_ch.tick_echo      = out_tick_r;

endmodule
`default_nettype wire
